/* hdl/kls_pkg.sv */
// Shared types and constants for the keyframe linear sampler.
`timescale 1ns / 1ps

package kls_pkg;

	localparam int TIME_W    = 32;
	localparam int VAL_W     = 32;
	localparam int COUNT_W   = 9;
	localparam int FRAC_W    = 16;
	localparam int QUOT_W    = FRAC_W + 1;
	localparam int DIV_STEPS = QUOT_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int DIFF_W    = VAL_W + 1;
	localparam int PROD_W    = DIFF_W + QUOT_W + 1;

	typedef struct packed {
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] z;
	} vec_t;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD0,
		ST_RD1,
		ST_CAP,
		ST_DIV,
		ST_MUL,
		ST_ACC
	} state_t;

	typedef enum logic [1:0] {
		COMP_X,
		COMP_Y,
		COMP_Z
	} comp_t;

endpackage

/* hdl/kls_keymem.sv */
// Keyframe time memory and value memory, one write port and one read port each.
`timescale 1ns / 1ps

module kls_keymem import kls_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [TIME_W-1:0] wtime,
	input  vec_t              wvec,
	input  logic [AW-1:0]     time_raddr,
	output logic [TIME_W-1:0] time_rdata,
	input  logic [AW-1:0]     vec_raddr,
	output vec_t              vec_rdata
);

	logic [TIME_W-1:0] time_mem [DEPTH];
	vec_t              vec_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[waddr] <= wtime;
			vec_mem[waddr]  <= wvec;
		end
	end

	always_ff @(posedge clk) begin
		time_rdata <= time_mem[time_raddr];
		vec_rdata  <= vec_mem[vec_raddr];
	end

endmodule

/* hdl/kls_frac_div.sv */
// Bit-serial restoring divider for the Q1.16 interpolation fraction.
`timescale 1ns / 1ps

module kls_frac_div import kls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [TIME_W-1:0] num,
	input  logic [TIME_W-1:0] den,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] den_q;
	logic              bit0_q;
	logic [QUOT_W-1:0] quot_q;
	logic [TIME_W:0]   trial;
	logic              ge;

	// num <= den, so the quotient fits in QUOT_W bits; start from num >> 1
	// and bring in num[0], then the FRAC_W zero bits of the shifted dividend.
	always_comb begin
		trial = {rem_q, (step_q == '0) ? bit0_q : 1'b0};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= {1'b0, num[TIME_W-1:1]};
			bit0_q <= num[0];
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? TIME_W'(trial - {1'b0, den_q}) : trial[TIME_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* hdl/keyframe_linear_sampler.sv */
// Top level of the keyframe linear sampler: sequencer, scan and shared multiplier.
`timescale 1ns / 1ps

// Usage:
// An item is taken at a rising edge with start high and busy low. cmd selects
// a keyframe write (key_index, key_time, key_x/y/z) or a sample at query_time.
// Every item gives exactly one result, shown for one cycle with done high:
// out_x/y/z, matched and table_empty. The receiver cannot hold results off.
// key_count is written through key_count_we / key_count_wdata; the user must
// do so only while idle, as the block does not enforce it. Write: the result
// appears the cycle after the transfer and busy stays low. Sample: the scan
// reads one key time per cycle from the time memory until it finds the
// bracketing pair or reaches the last key in use; states RD0, RD1 and CAP
// then fetch both key values, the bit-serial divider forms the fraction and
// the shared multiplier runs multiply then add, once per component. An
// unmatched query returns after the value fetch; an empty table returns
// like a write. The next item may be taken in the same cycle as done.
// Reset clears the sequencer and key_count; the key memories are not
// cleared, and entries must be written before a sample reads them.

module keyframe_linear_sampler import kls_pkg::*; #(
	parameter int MAX_KEYS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  logic [7:0]          key_index,
	input  logic [TIME_W-1:0]   key_time,
	input  logic signed [VAL_W-1:0] key_x,
	input  logic signed [VAL_W-1:0] key_y,
	input  logic signed [VAL_W-1:0] key_z,
	input  logic [TIME_W-1:0]   query_time,
	input  logic                key_count_we,
	input  logic [COUNT_W-1:0]  key_count_wdata,
	output logic                done,
	output logic signed [VAL_W-1:0] out_x,
	output logic signed [VAL_W-1:0] out_y,
	output logic signed [VAL_W-1:0] out_z,
	output logic                matched,
	output logic                table_empty
);

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);

	state_t             state_q, state_d;
	logic [COUNT_W-1:0] key_count_q;
	logic [CW-1:0]      n_clamp;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      i_q;
	logic [TIME_W-1:0]  q_q;
	logic [TIME_W-1:0]  t0_q;
	logic [TIME_W-1:0]  t1_q;
	logic [AW-1:0]      v_addr_q;
	logic               match_q;
	vec_t               v0_q;
	vec_t               v1_q;
	logic [QUOT_W-1:0]  f_q;
	comp_t              comp_q;
	logic signed [PROD_W-1:0] prod_q;

	logic               done_q;
	logic [VAL_W-1:0]   out_x_q, out_y_q, out_z_q;
	logic               matched_q, empty_q;

	logic               accept;
	logic               mem_we;
	logic [AW-1:0]      time_raddr, vec_raddr;
	logic [TIME_W-1:0]  time_rdata;
	vec_t               vec_rdata;
	vec_t               wvec;
	logic               hit, last, take_pair;
	logic               div_go, div_done;
	logic [QUOT_W-1:0]  div_quot;
	logic [VAL_W-1:0]   v0c, v1c;
	logic signed [DIFF_W-1:0] diff;
	logic signed [QUOT_W:0]   f_s;
	logic [VAL_W-1:0]   sum;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign mem_we = accept && (cmd == CMD_WRITE) && (32'(key_index) < MAX_KEYS);
	assign wvec   = '{x: key_x, y: key_y, z: key_z};

	always_comb begin
		if (32'(key_count_q) > MAX_KEYS) begin
			n_clamp = CW'(MAX_KEYS);
		end else begin
			n_clamp = CW'(key_count_q);
		end
	end

	assign hit       = (t0_q <= q_q) && (q_q <= time_rdata);
	assign last      = (i_q == n_q - CW'(1));
	assign take_pair = (i_q != '0) && hit;

	assign time_raddr = (state_q == ST_SCAN) ? AW'(i_q + CW'(1)) : '0;
	assign vec_raddr  = (state_q == ST_RD1) ? AW'(v_addr_q + AW'(1)) : v_addr_q;

	kls_keymem #(
		.DEPTH(MAX_KEYS),
		.AW   (AW)
	) u_keymem (
		.clk       (clk),
		.we        (mem_we),
		.waddr     (AW'(key_index)),
		.wtime     (key_time),
		.wvec      (wvec),
		.time_raddr(time_raddr),
		.time_rdata(time_rdata),
		.vec_raddr (vec_raddr),
		.vec_rdata (vec_rdata)
	);

	kls_frac_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.num   (q_q - t0_q),
		.den   (t1_q - t0_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	// Component selection for the shared multiplier
	always_comb begin
		case (comp_q)
			COMP_X: begin
				v0c = v0_q.x;
				v1c = v1_q.x;
			end
			COMP_Y: begin
				v0c = v0_q.y;
				v1c = v1_q.y;
			end
			COMP_Z: begin
				v0c = v0_q.z;
				v1c = v1_q.z;
			end
			default: begin
				v0c = v0_q.x;
				v1c = v1_q.x;
			end
		endcase
		diff = $signed({v1c[VAL_W-1], v1c}) - $signed({v0c[VAL_W-1], v0c});
		f_s  = $signed({1'b0, f_q});
		// arithmetic shift by FRAC_W floors toward minus infinity
		sum  = v0c + prod_q[FRAC_W+VAL_W-1:FRAC_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_go  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_SAMPLE && n_clamp != '0) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (take_pair || last) begin
					state_d = ST_RD0;
				end
			end
			ST_RD0: state_d = ST_RD1;
			ST_RD1: state_d = match_q ? ST_CAP : ST_IDLE;
			ST_CAP: begin
				if (t1_q == t0_q) begin
					state_d = ST_MUL;
				end else begin
					div_go  = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: state_d = (comp_q == COMP_Z) ? ST_IDLE : ST_MUL;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			done_q      <= 1'b0;
		end else begin
			if (key_count_we) begin
				key_count_q <= key_count_wdata;
			end
			done_q <= 1'b0;
			if (accept && (cmd == CMD_WRITE || n_clamp == '0)) begin
				done_q <= 1'b1;
			end else if (state_q == ST_RD1 && !match_q) begin
				done_q <= 1'b1;
			end else if (state_q == ST_ACC && comp_q == COMP_Z) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q       <= n_clamp;
					q_q       <= query_time;
					i_q       <= '0;
					out_x_q   <= '0;
					out_y_q   <= '0;
					out_z_q   <= '0;
					matched_q <= 1'b0;
					empty_q   <= (cmd == CMD_SAMPLE) && (n_clamp == '0);
				end
			end
			ST_SCAN: begin
				if (take_pair) begin
					t1_q     <= time_rdata;
					v_addr_q <= AW'(i_q - CW'(1));
					match_q  <= 1'b1;
				end else begin
					t0_q <= time_rdata;
					if (last) begin
						// no bracketing pair: fall back to the last key in use
						v_addr_q <= AW'(i_q);
						match_q  <= 1'b0;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
			end
			ST_RD1: begin
				v0_q <= vec_rdata;
				if (!match_q) begin
					out_x_q <= vec_rdata.x;
					out_y_q <= vec_rdata.y;
					out_z_q <= vec_rdata.z;
				end
			end
			ST_CAP: begin
				v1_q   <= vec_rdata;
				f_q    <= '0;
				comp_q <= COMP_X;
			end
			ST_DIV: begin
				if (div_done) begin
					f_q <= div_quot;
				end
			end
			ST_MUL: begin
				prod_q <= PROD_W'(diff) * PROD_W'(f_s);
			end
			ST_ACC: begin
				case (comp_q)
					COMP_X: begin
						out_x_q <= sum;
						comp_q  <= COMP_Y;
					end
					COMP_Y: begin
						out_y_q <= sum;
						comp_q  <= COMP_Z;
					end
					COMP_Z: begin
						out_z_q   <= sum;
						matched_q <= 1'b1;
					end
					default: comp_q <= COMP_X;
				endcase
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_z       = out_z_q;
	assign matched     = matched_q;
	assign table_empty = empty_q;

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_WRITE |=> done && !matched && !table_empty)
		else $error("write transfer did not give a plain result");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> i_q < n_q)
		else $error("scan index ran past the keys in use");

	a_div_interval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> t1_q != t0_q)
		else $error("divider running on a zero-length interval");

	a_match_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && matched |-> !table_empty)
		else $error("matched result flagged as empty table");

endmodule
